@@ rtl/aidp_pkg.sv @@
`timescale 1ns / 1ps
package aidp_pkg;

	localparam int unsigned MagW = 31;
	localparam int unsigned ValueW = 32;
	localparam int unsigned StatusW = 3;
	localparam int unsigned OutTdataW = 40;

	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharPlus = 8'h2B;
	localparam logic [7:0] CharDot = 8'h2E;
	localparam logic [7:0] CharLowF = 8'h66;
	localparam logic [7:0] CharUpF = 8'h46;
	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab = 8'h09;
	localparam logic [7:0] CharCr = 8'h0D;

	// largest magnitude that is still in range
	localparam logic [34:0] MagLimit = 35'h0_7FFF_FFFF;

	typedef enum logic [5:0] {
		PH_LEAD  = 6'b000001,
		PH_SIGN  = 6'b000010,
		PH_INT   = 6'b000100,
		PH_FRAC  = 6'b001000,
		PH_FEND  = 6'b010000,
		PH_TRAIL = 6'b100000
	} phase_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_NODIG = 3'd2,
		ST_INVAL = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef struct packed {
		phase_t           phase;
		logic             negative;
		logic [MagW-1:0]  magnitude;
		status_t          err;
	} parse_state_t;

	typedef struct packed {
		logic [ValueW-1:0] value;
		status_t           status;
	} parse_result_t;

	localparam parse_state_t StateInit = '{
		phase: PH_LEAD, negative: 1'b0, magnitude: '0, err: ST_OK
	};

endpackage

@@ rtl/aidp_step.sv @@
`timescale 1ns / 1ps
module aidp_step
	import aidp_pkg::*;
(
	input  parse_state_t  cur,
	input  logic [7:0]    char_code,
	input  logic          last,
	output parse_state_t  nxt,
	output parse_result_t result
);

	logic          is_space;
	logic          is_digit;
	logic          is_f;
	logic [34:0]   mag_x10;
	logic [34:0]   mag_sum;
	logic          mag_over;
	parse_state_t  upd;

	always_comb begin
		is_space = (char_code == CharSpace) || (char_code inside {[CharTab:CharCr]});
		is_digit = char_code inside {[CharZero:CharNine]};
		is_f     = (char_code == CharLowF) || (char_code == CharUpF);
	end

	// magnitude * 10 + digit, wide enough to see any overflow
	always_comb begin
		mag_x10  = {1'b0, cur.magnitude, 3'b000} + {3'b000, cur.magnitude, 1'b0};
		mag_sum  = mag_x10 + {31'd0, char_code[3:0] - CharZero[3:0]};
		mag_over = mag_sum > MagLimit;
	end

	always_comb begin
		upd = cur;
		if (cur.err == ST_OK) begin
			case (cur.phase)
				PH_LEAD: begin
					if (is_space) begin
						upd.phase = PH_LEAD;
					end else if (char_code == CharMinus) begin
						upd.negative = 1'b1;
						upd.phase = PH_SIGN;
					end else if (char_code == CharPlus) begin
						upd.phase = PH_SIGN;
					end else if (is_digit) begin
						upd.phase = PH_INT;
						if (mag_over) upd.err = ST_RANGE;
						else upd.magnitude = mag_sum[MagW-1:0];
					end else begin
						upd.err = ST_NODIG;
					end
				end
				PH_SIGN: begin
					if (is_digit) begin
						upd.phase = PH_INT;
						if (mag_over) upd.err = ST_RANGE;
						else upd.magnitude = mag_sum[MagW-1:0];
					end else begin
						upd.err = ST_NODIG;
					end
				end
				PH_INT: begin
					if (is_digit) begin
						if (mag_over) upd.err = ST_RANGE;
						else upd.magnitude = mag_sum[MagW-1:0];
					end else if (char_code == CharDot) begin
						upd.phase = PH_FRAC;
					end else if (is_f) begin
						upd.phase = PH_FEND;
					end else if (is_space) begin
						upd.phase = PH_TRAIL;
					end else begin
						upd.err = ST_INVAL;
					end
				end
				PH_FRAC: begin
					// drop fraction digits
					if (is_digit) begin
						upd.phase = PH_FRAC;
					end else if (is_f) begin
						upd.phase = PH_FEND;
					end else if (is_space) begin
						upd.phase = PH_TRAIL;
					end else begin
						upd.err = ST_INVAL;
					end
				end
				PH_FEND, PH_TRAIL: begin
					if (is_space) upd.phase = PH_TRAIL;
					else upd.err = ST_INVAL;
				end
				default: begin
					upd.err = ST_INVAL;
				end
			endcase
		end
	end

	always_comb begin
		if (upd.err != ST_OK) result.status = upd.err;
		else if (upd.phase == PH_LEAD) result.status = ST_EMPTY;
		else if (upd.phase == PH_SIGN) result.status = ST_NODIG;
		else result.status = ST_OK;

		if (result.status != ST_OK) result.value = '0;
		else if (upd.negative) result.value = ValueW'(0) - {1'b0, upd.magnitude};
		else result.value = {1'b0, upd.magnitude};

		nxt = last ? StateInit : upd;
	end

endmodule

@@ rtl/ascii_decimal_to_int_parser.sv @@
`timescale 1ns / 1ps
// ASCII decimal string to signed 32-bit integer.
//
// Input channel (s_*): one character per beat in s_tdata, s_tlast high on
// the final character of a string. Output channel (m_*): one beat per
// string, carrying value and status, sent for the beat that had s_tlast.
// Status: 0 ok, 1 empty, 2 no digits, 3 invalid character, 4 out of range;
// value is zero unless status is ok. Magnitudes above 2147483647 are out of
// range for either sign, so -2147483648 reports status 4.
//
// A result appears on m_tvalid after its last character is accepted: the
// input register loads at the accepting edge, and the result register
// loads from it once free. Throughput: one character per cycle unless a
// last character waits on a stuck result, set by the combinational parse
// step between the input register and the parse state / result registers.
//
// Reset (arst_n low) empties both registers and returns the parse state to
// the start of a string. When the receiver holds m_tready low, the result
// register holds; characters that produce no result keep flowing, and only
// a second last character waits in the input register until the result
// register frees.
module ascii_decimal_to_int_parser
	import aidp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] char_code
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutTdataW-1:0] m_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          go_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t result_nxt;
	parse_result_t result_q;
	logic          out_valid_q;

	// advance stage 1 unless it holds a last character and the result is stuck
	assign go_s1    = valid_s1 && !(last_s1 && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	aidp_step u_step (
		.cur       (state_q),
		.char_code (char_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.result    (result_nxt)
	);

	// parse state follows each consumed character, back to start after last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateInit;
		end else if (go_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			result_q <= result_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, result_q.status, result_q.value};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import aidp_pkg::*;

	localparam int RandomBeats = 1950;
	localparam int CalmTail = 250;
	localparam int CycleLimit = 600000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // [7:0] char_code
	logic s_tlast;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutTdataW-1:0] m_tdata;   // [31:0] value, [34:32] status, [39:35] zero

	ascii_decimal_to_int_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Parser state mirror
	phase_t p_phase = PH_LEAD;
	logic p_neg = 1'b0;
	logic [MagW-1:0] p_mag = '0;
	status_t p_err = ST_OK;

	parse_result_t pending_parses[$];
	logic [7:0] str_q[$];

	int beats_sent = 0;
	int strings_sent = 0;
	int results_seen = 0;
	int status_tally[5] = '{default: 0};
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit rx_choppy = 1'b1;
	int stall_left = 0;
	parse_result_t head;

	typedef struct {
		string txt;
		bit typed;
		int val;
		status_t st;
	} dir_row_t;

	dir_row_t dir_rows[20];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("ascii_decimal_to_int_parser verification failed");
			$finish;
		end
	end

	function automatic void take_digit(input logic [7:0] c);
		logic [34:0] nxt;
		nxt = p_mag * 35'd10 + (c - CharZero);
		if (nxt > MagLimit)
			p_err = ST_RANGE;
		else
			p_mag = nxt[MagW-1:0];
	endfunction

	// Advance the mirror by one character; return 1 when the character ends a string.
	function automatic bit atoi_step(input logic [7:0] c, input bit lst,
			output parse_result_t res);
		bit sp;
		bit dg;
		bit ff;
		sp = (c == CharSpace) || (c >= CharTab && c <= CharCr);
		dg = (c >= CharZero) && (c <= CharNine);
		ff = (c == CharLowF) || (c == CharUpF);
		res = '{value: '0, status: ST_OK};
		if (p_err == ST_OK) begin
			case (p_phase)
				PH_LEAD: begin
					if (!sp) begin
						if (c == CharMinus) begin
							p_neg = 1'b1;
							p_phase = PH_SIGN;
						end else if (c == CharPlus) begin
							p_phase = PH_SIGN;
						end else if (dg) begin
							take_digit(c);
							p_phase = PH_INT;
						end else begin
							p_err = ST_NODIG;
						end
					end
				end
				PH_SIGN: begin
					if (dg) begin
						take_digit(c);
						p_phase = PH_INT;
					end else begin
						p_err = ST_NODIG;
					end
				end
				PH_INT: begin
					if (dg)
						take_digit(c);
					else if (c == CharDot)
						p_phase = PH_FRAC;
					else if (ff)
						p_phase = PH_FEND;
					else if (sp)
						p_phase = PH_TRAIL;
					else
						p_err = ST_INVAL;
				end
				PH_FRAC: begin
					// fraction digits are dropped
					if (!dg) begin
						if (ff)
							p_phase = PH_FEND;
						else if (sp)
							p_phase = PH_TRAIL;
						else
							p_err = ST_INVAL;
					end
				end
				PH_FEND, PH_TRAIL: begin
					if (sp)
						p_phase = PH_TRAIL;
					else
						p_err = ST_INVAL;
				end
				default: p_err = ST_INVAL;
			endcase
		end
		if (!lst)
			return 1'b0;
		if (p_err != ST_OK)
			res.status = p_err;
		else if (p_phase == PH_LEAD)
			res.status = ST_EMPTY;
		else if (p_phase == PH_SIGN)
			res.status = ST_NODIG;
		else
			res.status = ST_OK;
		if (res.status == ST_OK)
			res.value = p_neg ? -{1'b0, p_mag} : {1'b0, p_mag};
		p_phase = PH_LEAD;
		p_neg = 1'b0;
		p_mag = '0;
		p_err = ST_OK;
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_space();
		if ($urandom_range(0, 2) == 0)
			return CharTab + 8'($urandom_range(0, 4));
		return CharSpace;
	endfunction

	// Drive every character of str_q, last flag on the final one.
	task automatic send_str();
		parse_result_t res;
		int gap;
		bit bursty;
		bursty = !calm && ($urandom_range(0, 3) != 0);
		for (int i = 0; i < str_q.size(); i++) begin
			gap = (bursty && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			s_tvalid <= 1'b1;
			s_tdata <= str_q[i];
			s_tlast <= (i == str_q.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			beats_sent++;
			if (atoi_step(str_q[i], i == str_q.size() - 1, res))
				pending_parses.push_back(res);
		end
		strings_sent++;
	endtask

	// Drop valid and hold until every parse result has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_parses.size() != 0) @(posedge clk);
	endtask

	task automatic build_random();
		int k;
		int pos;
		int unsigned n;
		string num_txt;
		str_q.delete();
		k = $urandom_range(0, 19);
		if (k == 17) begin
			repeat ($urandom_range(1, 4)) str_q.push_back(rand_space());
			return;
		end
		if (k == 18) begin
			repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) str_q.push_back(rand_space());
		case ($urandom_range(0, 2))
			1: str_q.push_back(CharPlus);
			2: str_q.push_back(CharMinus);
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0, 1: n = $urandom_range(0, 9999);
			2: n = $urandom;
			3: n = 32'd2147483600 + $urandom_range(0, 99);
			5: n = $urandom_range(0, 2147483647);
			default: n = 0;
		endcase
		num_txt = $sformatf("%0d", n);
		if (n == 0) begin
			// free-form digit run, leading zeros and over-long runs included
			repeat ($urandom_range(1, 13)) str_q.push_back(CharZero + 8'($urandom_range(0, 9)));
		end else begin
			for (int i = 0; i < num_txt.len(); i++)
				str_q.push_back(num_txt[i]);
		end
		if ($urandom_range(0, 3) == 0) begin
			str_q.push_back(CharDot);
			repeat ($urandom_range(0, 3)) str_q.push_back(CharZero + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 4) == 0)
			str_q.push_back($urandom_range(0, 1) ? CharLowF : CharUpF);
		repeat ($urandom_range(0, 2)) str_q.push_back(rand_space());
		// for k of 14 to 16, break the well-formed string: overwrite or insert a character
		pos = $urandom_range(0, str_q.size() - 1);
		if (k == 14 || k == 15)
			str_q[pos] = 8'($urandom_range(0, 255));
		else if (k == 16)
			str_q.insert(pos, $urandom_range(0, 1) ? CharDot : rand_space());
	endtask

	// Receiver: random stall bursts, switched off in the calm tail.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && rx_choppy && $urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
		if ($urandom_range(0, 79) == 0)
			rx_choppy = !rx_choppy;
	end

	// Compare each result beat with the oldest pending parse.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_parses.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual value %0d status %0d",
					$time, $signed(m_tdata[31:0]), m_tdata[34:32]);
			end else begin
				head = pending_parses.pop_front();
				results_seen++;
				if (head.status <= ST_RANGE)
					status_tally[head.status]++;
				if (m_tdata[31:0] !== head.value) begin
					errors++;
					$display("%0t: value mismatch: expected %0d, actual %0d",
						$time, $signed(head.value), $signed(m_tdata[31:0]));
				end
				if (m_tdata[34:32] !== head.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, head.status, m_tdata[34:32]);
				end
			end
		end
	end

	initial begin
		dir_rows = '{
			'{" ", 1, 0, ST_EMPTY},
			'{"\011\012\013\014\015", 1, 0, ST_EMPTY},
			'{"0", 1, 0, ST_OK},
			'{"2147483647", 1, 2147483647, ST_OK},
			'{"-2147483647", 1, -2147483647, ST_OK},
			'{"2147483648", 1, 0, ST_RANGE},
			'{"-2147483648", 1, 0, ST_RANGE},
			'{"99999999999", 1, 0, ST_RANGE},
			'{"-", 1, 0, ST_NODIG},
			'{"+ ", 1, 0, ST_NODIG},
			'{".", 1, 0, ST_NODIG},
			'{"x7", 1, 0, ST_NODIG},
			'{"\377", 1, 0, ST_NODIG},
			'{"1 2", 1, 0, ST_INVAL},
			'{"3.5.1", 1, 0, ST_INVAL},
			'{"4f5", 1, 0, ST_INVAL},
			'{"7\200", 1, 0, ST_INVAL},
			'{" +0 ", 0, 0, ST_OK},
			'{"42.75F  ", 0, 0, ST_OK},
			'{"-9f", 0, 0, ST_OK}
		};

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed strings; typed rows override the mirror's prediction.
		foreach (dir_rows[r]) begin
			str_q.delete();
			for (int i = 0; i < dir_rows[r].txt.len(); i++)
				str_q.push_back(dir_rows[r].txt[i]);
			send_str();
			if (dir_rows[r].typed)
				pending_parses[pending_parses.size() - 1] =
					'{value: dir_rows[r].val, status: dir_rows[r].st};
		end
		drain();

		// Random strings, mostly well formed with random content.
		while (beats_sent < RandomBeats) begin
			if (beats_sent > RandomBeats / 2 && beats_sent < RandomBeats / 2 + 8)
				drain();
			calm = (beats_sent >= RandomBeats - CalmTail);
			build_random();
			send_str();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d strings in %0d beats; checked %0d results", strings_sent,
			beats_sent, results_seen);
		$display("Results by status: ok %0d, empty %0d, no digits %0d, invalid %0d, range %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4]);
		if (errors == 0) begin
			$display("ascii_decimal_to_int_parser verification clean");
		end else begin
			$display("ascii_decimal_to_int_parser verification failed");
		end
		$finish;
	end

endmodule
